>>> src/gbnp_pkg.sv
package gbnp_pkg;

  // Default grid shape and bucket depth
  localparam int unsigned GRID_COLS_DEF  = 16;
  localparam int unsigned GRID_ROWS_DEF  = 16;
  localparam int unsigned CELL_DEPTH_DEF = 32;

  // Field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned TAG_W    = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] PLOT_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] PLOT_HEIGHT_RST = 13'd480;

  // Modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OFF  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // Proximity limits
  localparam int unsigned NEAR_PIX = 10;
  localparam int unsigned NEAR_SQ  = 100;

  // Filing targets in order: own, left, right, up, down, up-left, up-right,
  // down-left, down-right. Bit k set when target k sits on that side.
  localparam int unsigned NUM_TGT = 9;
  localparam logic [NUM_TGT-1:0] TGT_UP    = 9'h068;
  localparam logic [NUM_TGT-1:0] TGT_DOWN  = 9'h190;
  localparam logic [NUM_TGT-1:0] TGT_LEFT  = 9'h0A2;
  localparam logic [NUM_TGT-1:0] TGT_RIGHT = 9'h144;

endpackage

>>> src/grid_bucket_nearest_point.sv
// Nearest-point lookup over a uniform grid of buckets.
//
// Input channel (in_valid_i/in_ready_o) carries one request: mode, pos_x,
// pos_y, entry_row, entry_col. Each request gives exactly one response on
// the output channel (out_valid_o/out_ready_i): status, result_row,
// result_col. The config channel (cfg_valid_i/cfg_ready_o) writes
// plot_width (index 0) or plot_height (index 1); it is always ready.
//
// Requests are handled one at a time. Insert and find take the cell size
// from a reciprocal multiply at accept, then run two 13-step divisions on
// one shared restoring divider (cell coordinates). Insert then walks the
// filing targets: each filed cell (up to 9) takes a select and a check step,
// each skipped target a select step, and a last select step finishes. Find
// reads the fill count of the own cell, then scans its stored entries, one
// entry read per cycle. Off-screen requests and mode 3 go straight to the
// response. Clear sweeps the fill memory. Reset runs the same sweep before
// the first request is accepted. The next request can be accepted in the
// cycle after a response is loaded; a finished response holds until the
// receiver takes the earlier one.
module grid_bucket_nearest_point #(
  parameter int unsigned GRID_COLS  = gbnp_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS  = gbnp_pkg::GRID_ROWS_DEF,
  parameter int unsigned CELL_DEPTH = gbnp_pkg::CELL_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [gbnp_pkg::MODE_W-1:0]         mode_i,
  input  logic signed [gbnp_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [gbnp_pkg::POS_W-1:0]   pos_y_i,
  input  logic [gbnp_pkg::TAG_W-1:0]          entry_row_i,
  input  logic [gbnp_pkg::TAG_W-1:0]          entry_col_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gbnp_pkg::STATUS_W-1:0]       status_o,
  output logic [gbnp_pkg::TAG_W-1:0]          result_row_o,
  output logic [gbnp_pkg::TAG_W-1:0]          result_col_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gbnp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gbnp_pkg::DIM_W-1:0]          cfg_data_i
);

  localparam int unsigned NCELLS = GRID_COLS * GRID_ROWS;
  localparam int unsigned CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int unsigned CI_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int unsigned RI_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int unsigned FW     = $clog2(CELL_DEPTH + 1);
  localparam int unsigned ENT_N  = NCELLS * CELL_DEPTH;
  localparam int unsigned ENT_AW = (ENT_N > 1) ? $clog2(ENT_N) : 1;
  localparam int unsigned DW     = gbnp_pkg::DIM_W;
  localparam int unsigned CW     = gbnp_pkg::TAG_W;
  localparam int unsigned ENT_W  = 4 * CW;
  localparam logic [3:0]  DIV_LAST = 4'(DW - 1);

  // Reciprocals for the rounded-up cell size, exact over the numerator range
  localparam int unsigned SZ_NW  = DW + 1;
  localparam int unsigned COL_SH = SZ_NW + CI_W;
  localparam int unsigned ROW_SH = SZ_NW + RI_W;
  localparam int unsigned RCP_W  = 16;
  localparam logic [RCP_W-1:0] COL_RCP =
    RCP_W'(((64'd1 << COL_SH) + 64'(GRID_COLS) - 64'd1) / 64'(GRID_COLS));
  localparam logic [RCP_W-1:0] ROW_RCP =
    RCP_W'(((64'd1 << ROW_SH) + 64'(GRID_ROWS) - 64'd1) / 64'(GRID_ROWS));

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_INS_SEL, S_INS_CHK,
    S_FND_RD, S_FND_N, S_FND_SCAN, S_DONE
  } state_e;

  state_e state_q;
  logic [DW-1:0] width_q, height_q;
  logic [CELL_W-1:0] clr_idx_q;
  logic init_q;

  // Request holding registers
  logic [gbnp_pkg::MODE_W-1:0] mode_q;
  logic [CW-1:0] px_q, py_q, row_q, col_q;

  // Cell size
  logic [SZ_NW-1:0] cols_num, rows_num;
  logic [SZ_NW+RCP_W-1:0] cols_prod, rows_prod;
  logic [DW-1:0] cw_calc, ch_calc;

  // Divider
  logic          div_sel_q;
  logic [3:0]    div_cnt_q;
  logic [DW-1:0] div_n_q, div_r_q, div_d;
  logic [DW:0]   rem_sh;
  logic          rem_ge;
  logic [DW-1:0] quo_nxt, rem_nxt;
  logic [DW-1:0] cw_q, ch_q, cr_q, rr_q;
  logic [CI_W-1:0] ci_q;
  logic [RI_W-1:0] ri_q;
  logic near_l, near_r, near_t, near_b;

  // Target walk
  logic [3:0] tgt_q;
  logic [gbnp_pkg::NUM_TGT-1:0] tgt_en;
  logic [RI_W:0] trow;
  logic [CI_W:0] tcol;
  logic [CELL_W-1:0] tcell, cell_q;
  logic fail_q;

  // Memories
  logic [FW-1:0]    fill_mem [NCELLS];
  logic [FW-1:0]    fill_rdata_q, fill_wdata;
  logic [CELL_W-1:0] fill_waddr;
  logic             fill_we;
  logic [ENT_W-1:0] ent_mem [ENT_N];
  logic [ENT_W-1:0] ent_rdata_q;
  logic [ENT_AW-1:0] ent_base, ent_waddr, ent_raddr;
  logic             ent_we, cell_full;

  // Scan
  logic [FW-1:0] scan_k_q, scan_n_q;
  logic          scan_issue, pend_q, hit_q;
  logic [7:0]    best_q;
  logic signed [DW:0] dx, dy;
  logic [DW:0]   adx, ady;
  logic [7:0]    sq_dist;
  logic          close_enough;

  // Result
  logic [gbnp_pkg::STATUS_W-1:0] res_st_q, status_q;
  logic [CW-1:0] res_row_q, res_col_q, out_row_q, out_col_q;
  logic out_valid_q, rsp_load;

  logic in_acc, off_screen;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign result_row_o = out_row_q;
  assign result_col_o = out_col_q;
  assign rsp_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign off_screen = pos_x_i[DW-1] || pos_y_i[DW-1] ||
                      (DW'(pos_x_i) >= width_q) || (DW'(pos_y_i) >= height_q);

  // Rounded-up cell size by reciprocal multiply
  assign cols_num  = {1'b0, width_q} + SZ_NW'(GRID_COLS - 1);
  assign rows_num  = {1'b0, height_q} + SZ_NW'(GRID_ROWS - 1);
  assign cols_prod = (SZ_NW+RCP_W)'(cols_num) * (SZ_NW+RCP_W)'(COL_RCP);
  assign rows_prod = (SZ_NW+RCP_W)'(rows_num) * (SZ_NW+RCP_W)'(ROW_RCP);
  assign cw_calc   = DW'(cols_prod >> COL_SH);
  assign ch_calc   = DW'(rows_prod >> ROW_SH);

  // Divisor per division
  assign div_d = div_sel_q ? ch_q : cw_q;

  // One restoring step
  assign rem_sh  = {div_r_q, div_n_q[DW-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_d};
  assign rem_nxt = rem_ge ? DW'(rem_sh - {1'b0, div_d}) : rem_sh[DW-1:0];
  assign quo_nxt = {div_n_q[DW-2:0], rem_ge};

  // Edge proximity within the own cell
  assign near_l = (cr_q < DW'(gbnp_pkg::NEAR_PIX)) && (ci_q != '0);
  assign near_r = ({1'b0, cr_q} + (DW+1)'(gbnp_pkg::NEAR_PIX) >= {1'b0, cw_q}) &&
                  (32'(ci_q) < GRID_COLS - 1);
  assign near_t = (rr_q < DW'(gbnp_pkg::NEAR_PIX)) && (ri_q != '0);
  assign near_b = ({1'b0, rr_q} + (DW+1)'(gbnp_pkg::NEAR_PIX) >= {1'b0, ch_q}) &&
                  (32'(ri_q) < GRID_ROWS - 1);

  // Target enables and target cell
  always_comb begin
    for (int k = 0; k < gbnp_pkg::NUM_TGT; k++) begin
      tgt_en[k] = (!gbnp_pkg::TGT_UP[k]    || near_t) &&
                  (!gbnp_pkg::TGT_DOWN[k]  || near_b) &&
                  (!gbnp_pkg::TGT_LEFT[k]  || near_l) &&
                  (!gbnp_pkg::TGT_RIGHT[k] || near_r);
    end
    trow = {1'b0, ri_q};
    tcol = {1'b0, ci_q};
    if (tgt_q < 4'(gbnp_pkg::NUM_TGT)) begin
      if (gbnp_pkg::TGT_UP[tgt_q])    trow = trow - 1'b1;
      if (gbnp_pkg::TGT_DOWN[tgt_q])  trow = trow + 1'b1;
      if (gbnp_pkg::TGT_LEFT[tgt_q])  tcol = tcol - 1'b1;
      if (gbnp_pkg::TGT_RIGHT[tgt_q]) tcol = tcol + 1'b1;
    end
    tcell = CELL_W'(32'(trow) * GRID_COLS + 32'(tcol));
  end

  // Memory addressing and write controls
  assign cell_full  = fill_rdata_q >= FW'(CELL_DEPTH);
  assign ent_base   = ENT_AW'(32'(cell_q) * CELL_DEPTH);
  assign ent_waddr  = ent_base + ENT_AW'(fill_rdata_q);
  assign ent_raddr  = ent_base + ENT_AW'(scan_k_q);
  assign ent_we     = (state_q == S_INS_CHK) && !cell_full;
  assign fill_we    = (state_q == S_CLR) || ent_we;
  assign fill_waddr = (state_q == S_CLR) ? clr_idx_q : cell_q;
  assign fill_wdata = (state_q == S_CLR) ? '0 : FW'(fill_rdata_q + 1'b1);
  assign scan_issue = (state_q == S_FND_SCAN) && (scan_k_q < scan_n_q);

  // Fill count memory
  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rdata_q <= fill_mem[tcell];
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= {px_q, py_q, row_q, col_q};
    ent_rdata_q <= ent_mem[ent_raddr];
  end

  // Distance of the entry just read; far entries never need a square
  always_comb begin
    dx  = $signed({2'b00, px_q}) - $signed({2'b00, ent_rdata_q[ENT_W-1 -: CW]});
    dy  = $signed({2'b00, py_q}) - $signed({2'b00, ent_rdata_q[ENT_W-CW-1 -: CW]});
    adx = dx[DW] ? DW'(-dx) : DW'(dx);
    ady = dy[DW] ? DW'(-dy) : DW'(dy);
    sq_dist = 8'(adx[3:0] * adx[3:0]) + 8'(ady[3:0] * ady[3:0]);
    close_enough = (adx <= (DW+1)'(gbnp_pkg::NEAR_PIX)) &&
                   (ady <= (DW+1)'(gbnp_pkg::NEAR_PIX)) &&
                   (sq_dist <= 8'(gbnp_pkg::NEAR_SQ));
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_idx_q   <= '0;
      init_q      <= 1'b1;
      width_q     <= gbnp_pkg::PLOT_WIDTH_RST;
      height_q    <= gbnp_pkg::PLOT_HEIGHT_RST;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      // Write configuration
      if (cfg_valid_i) begin
        unique case (cfg_idx_i)
          gbnp_pkg::REG_PLOT_WIDTH:  width_q  <= cfg_data_i;
          gbnp_pkg::REG_PLOT_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Load a finished response or drop a taken one
      if (rsp_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      pend_q <= scan_issue;
      if (pend_q && close_enough && (!hit_q || sq_dist < best_q)) begin
        hit_q     <= 1'b1;
        best_q    <= sq_dist;
        res_row_q <= ent_rdata_q[2*CW-1 -: CW];
        res_col_q <= ent_rdata_q[CW-1:0];
      end

      unique case (state_q)
        S_CLR: begin
          if (32'(clr_idx_q) == NCELLS - 1) begin
            clr_idx_q <= '0;
            init_q    <= 1'b0;
            state_q   <= init_q ? S_IDLE : S_DONE;
          end else begin
            clr_idx_q <= clr_idx_q + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            mode_q    <= mode_i;
            px_q      <= CW'(pos_x_i);
            py_q      <= CW'(pos_y_i);
            row_q     <= entry_row_i;
            col_q     <= entry_col_i;
            res_st_q  <= gbnp_pkg::ST_OK;
            res_row_q <= '0;
            res_col_q <= '0;
            hit_q     <= 1'b0;
            best_q    <= '0;
            fail_q    <= 1'b0;
            tgt_q     <= '0;
            unique case (mode_i)
              gbnp_pkg::MODE_CLEAR: state_q <= S_CLR;
              gbnp_pkg::MODE_INSERT, gbnp_pkg::MODE_FIND: begin
                if (off_screen) begin
                  res_st_q <= gbnp_pkg::ST_OFF;
                  state_q  <= S_DONE;
                end else begin
                  cw_q      <= cw_calc;
                  ch_q      <= ch_calc;
                  div_sel_q <= 1'b0;
                  div_cnt_q <= '0;
                  div_r_q   <= '0;
                  div_n_q   <= DW'(pos_x_i);
                  state_q   <= S_DIV;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end

        S_DIV: begin
          if (div_cnt_q == DIV_LAST) begin
            div_cnt_q <= '0;
            div_r_q   <= '0;
            div_sel_q <= 1'b1;
            if (!div_sel_q) begin
              ci_q    <= CI_W'(quo_nxt);
              cr_q    <= rem_nxt;
              div_n_q <= DW'(py_q);
            end else begin
              ri_q    <= RI_W'(quo_nxt);
              rr_q    <= rem_nxt;
              state_q <= (mode_q == gbnp_pkg::MODE_INSERT) ? S_INS_SEL : S_FND_RD;
            end
          end else begin
            div_cnt_q <= div_cnt_q + 1'b1;
            div_n_q   <= quo_nxt;
            div_r_q   <= rem_nxt;
          end
        end

        S_INS_SEL: begin
          cell_q <= tcell;
          if (tgt_q == 4'(gbnp_pkg::NUM_TGT)) begin
            if (fail_q) res_st_q <= gbnp_pkg::ST_FULL;
            state_q <= S_DONE;
          end else if (tgt_en[tgt_q]) begin
            state_q <= S_INS_CHK;
          end else begin
            tgt_q <= tgt_q + 1'b1;
          end
        end

        S_INS_CHK: begin
          if (cell_full) fail_q <= 1'b1;
          tgt_q   <= tgt_q + 1'b1;
          state_q <= S_INS_SEL;
        end

        S_FND_RD: begin
          cell_q  <= tcell;
          state_q <= S_FND_N;
        end

        S_FND_N: begin
          scan_n_q <= fill_rdata_q;
          scan_k_q <= '0;
          state_q  <= S_FND_SCAN;
        end

        S_FND_SCAN: begin
          if (scan_issue) begin
            scan_k_q <= scan_k_q + 1'b1;
          end else if (!pend_q) begin
            if (!hit_q) res_st_q <= gbnp_pkg::ST_NONE;
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          if (rsp_load) begin
            status_q    <= res_st_q;
            out_row_q   <= hit_q ? res_row_q : '0;
            out_col_q   <= hit_q ? res_col_q : '0;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |-> (32'(fill_wdata) <= CELL_DEPTH))
    else $error("fill count beyond bucket depth");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_d != '0))
    else $error("divide by zero");

  a_scan_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(state_q) == S_FND_SCAN))
    else $error("entry read outside scan");

endmodule
